@@ hdl/bthalloc_pkg.sv @@
// Shared types and constants for the boundary-tag heap allocator.
package bthalloc_pkg;

  // Request field codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Response status codes.
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

  // Tag geometry, in 8-byte heap words.
  localparam int TAG_SHIFT   = 3;
  localparam int MIN_BLOCK_W = 2;
  localparam int MIN_REM_W   = 3;

  // Two tags plus the round-up slack, in bytes.
  localparam int NEED_PAD    = 23;
  localparam int REQ_W       = 14;
  localparam int OFF_W       = 13;
  localparam int NEED_W      = REQ_W + 1 - TAG_SHIFT;
  localparam int TGT_W       = OFF_W - TAG_SHIFT;

  typedef struct packed {
    logic             func;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0] result_offset;
    logic             status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_INIT_HDR,
    ST_INIT_TRL,
    ST_IDLE,
    ST_WALK,
    ST_NEXT_CHK,
    ST_PREV_TAG,
    ST_PREV_HDR,
    ST_WR_HDR1,
    ST_WR_TRL1,
    ST_WR_HDR2,
    ST_WR_TRL2,
    ST_FINISH
  } state_t;

endpackage

@@ hdl/bthalloc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bthalloc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/bthalloc_ctrl.sv @@
// Sequencer that walks, splits and merges heap blocks through the tag memory.
module bthalloc_ctrl #(
  parameter int HEAP_BYTES = 8192,
  localparam int WORDS = HEAP_BYTES / 8,
  localparam int AW    = $clog2(WORDS),
  localparam int SW    = $clog2(WORDS + 1),
  localparam int TW    = SW + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bthalloc_pkg::req_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bthalloc_pkg::rsp_t  out_data,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [TW-1:0]       mem_wdata,
  output logic [AW-1:0]       mem_raddr,
  input  logic [TW-1:0]       mem_rdata
);

  localparam int PW  = SW + 1;
  localparam int CW  = ((SW > bthalloc_pkg::NEED_W) ? SW : bthalloc_pkg::NEED_W) + 1;
  localparam int XW  = ((PW + bthalloc_pkg::TAG_SHIFT) > bthalloc_pkg::OFF_W) ?
                       (PW + bthalloc_pkg::TAG_SHIFT) : bthalloc_pkg::OFF_W;
  localparam int REQ_SUM_W = bthalloc_pkg::REQ_W + 1;

  bthalloc_pkg::state_t state, state_next;

  logic                             is_free, is_free_next;
  logic [bthalloc_pkg::NEED_W-1:0]  need, need_next;
  logic [bthalloc_pkg::TGT_W-1:0]   tgt, tgt_next;
  logic [PW-1:0]                    pos, pos_next;
  logic [AW-1:0]                    s1, s1_next, s2, s2_next;
  logic [SW-1:0]                    z1, z1_next, z2, z2_next, psz, psz_next;
  logic                             u1, u1_next, two, two_next;
  logic [bthalloc_pkg::OFF_W-1:0]   res_off, res_off_next;
  logic                             res_st, res_st_next;
  logic                             out_load;

  logic [SW-1:0]                    rd_size;
  logic                             rd_used;
  logic [PW-1:0]                    pos_sum, pos_p1;
  logic [CW-1:0]                    pos_c, sum_c, tgt_c, need_c, size_c, left_c;
  logic [XW-1:0]                    off_wide;
  logic [REQ_SUM_W-1:0]             need_sum;
  logic [PW-1:0]                    trl1, trl2;
  logic [PW-1:0]                    prev_addr;

  assign rd_size  = mem_rdata[TW-1:1];
  assign rd_used  = mem_rdata[0];
  assign pos_sum  = pos + PW'(rd_size);
  assign pos_p1   = pos + PW'(1);
  assign off_wide = XW'(pos_p1) << bthalloc_pkg::TAG_SHIFT;
  assign pos_c    = CW'(pos);
  assign sum_c    = CW'(pos_sum);
  assign tgt_c    = CW'(tgt);
  assign need_c   = CW'(need);
  assign size_c   = CW'(rd_size);
  assign left_c   = size_c - need_c;
  assign need_sum = REQ_SUM_W'(in_data.request_bytes) + REQ_SUM_W'(bthalloc_pkg::NEED_PAD);
  assign trl1     = PW'(s1) + PW'(z1) - PW'(1);
  assign trl2     = PW'(s2) + PW'(z2) - PW'(1);
  assign prev_addr = PW'(s1) - PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bthalloc_pkg::ST_INIT_HDR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_free <= is_free_next;
    need    <= need_next;
    tgt     <= tgt_next;
    pos     <= pos_next;
    s1      <= s1_next;
    z1      <= z1_next;
    u1      <= u1_next;
    s2      <= s2_next;
    z2      <= z2_next;
    two     <= two_next;
    psz     <= psz_next;
    res_off <= res_off_next;
    res_st  <= res_st_next;
    if (out_load) begin
      out_data.result_offset <= res_off;
      out_data.status        <= res_st;
    end
  end

  always_comb begin
    state_next   = state;
    is_free_next = is_free;
    need_next    = need;
    tgt_next     = tgt;
    pos_next     = pos;
    s1_next      = s1;
    z1_next      = z1;
    u1_next      = u1;
    s2_next      = s2;
    z2_next      = z2;
    two_next     = two;
    psz_next     = psz;
    res_off_next = res_off;
    res_st_next  = res_st;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;

    case (state)
      bthalloc_pkg::ST_INIT_HDR: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = {SW'(WORDS), 1'b0};
        state_next = bthalloc_pkg::ST_INIT_TRL;
      end

      bthalloc_pkg::ST_INIT_TRL: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(WORDS - 1);
        mem_wdata  = {SW'(WORDS), 1'b0};
        state_next = bthalloc_pkg::ST_IDLE;
      end

      bthalloc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          is_free_next = (in_data.func == bthalloc_pkg::FUNC_FREE);
          need_next    = need_sum[REQ_SUM_W-1:bthalloc_pkg::TAG_SHIFT];
          tgt_next     = in_data.payload_offset[bthalloc_pkg::OFF_W-1:bthalloc_pkg::TAG_SHIFT]
                         - bthalloc_pkg::TGT_W'(1);
          pos_next     = '0;
          res_off_next = '0;
          res_st_next  = bthalloc_pkg::STATUS_DONE;
          mem_raddr    = '0;
          // A free below the first payload or off a word boundary matches no block.
          if (in_data.func == bthalloc_pkg::FUNC_FREE &&
              (in_data.payload_offset[bthalloc_pkg::OFF_W-1:bthalloc_pkg::TAG_SHIFT] == '0 ||
               in_data.payload_offset[bthalloc_pkg::TAG_SHIFT-1:0] != '0)) begin
            state_next = bthalloc_pkg::ST_FINISH;
          end else begin
            state_next = bthalloc_pkg::ST_WALK;
          end
        end
      end

      bthalloc_pkg::ST_WALK: begin
        mem_raddr = pos_sum[AW-1:0];
        if (!is_free) begin
          if (rd_size < SW'(bthalloc_pkg::MIN_BLOCK_W)) begin
            res_st_next = bthalloc_pkg::STATUS_NOFIT;
            state_next  = bthalloc_pkg::ST_FINISH;
          end else if (!rd_used && size_c >= need_c) begin
            s1_next      = pos[AW-1:0];
            u1_next      = 1'b1;
            res_off_next = off_wide[bthalloc_pkg::OFF_W-1:0];
            state_next   = bthalloc_pkg::ST_WR_HDR1;
            if (left_c >= CW'(bthalloc_pkg::MIN_REM_W)) begin
              z1_next  = need[SW-1:0];
              s2_next  = AW'(pos_c + need_c);
              z2_next  = left_c[SW-1:0];
              two_next = 1'b1;
            end else begin
              z1_next  = rd_size;
              two_next = 1'b0;
            end
          end else if (sum_c < CW'(WORDS)) begin
            pos_next = pos_sum;
          end else begin
            res_st_next = bthalloc_pkg::STATUS_NOFIT;
            state_next  = bthalloc_pkg::ST_FINISH;
          end
        end else begin
          if (pos_c == tgt_c) begin
            if (rd_used) begin
              s1_next  = pos[AW-1:0];
              z1_next  = rd_size;
              u1_next  = 1'b0;
              two_next = 1'b0;
              if (sum_c < CW'(WORDS)) begin
                state_next = bthalloc_pkg::ST_NEXT_CHK;
              end else if (pos != '0) begin
                mem_raddr  = AW'(pos - PW'(1));
                state_next = bthalloc_pkg::ST_PREV_TAG;
              end else begin
                state_next = bthalloc_pkg::ST_WR_HDR1;
              end
            end else begin
              state_next = bthalloc_pkg::ST_FINISH;
            end
          end else if (rd_size < SW'(bthalloc_pkg::MIN_BLOCK_W)) begin
            state_next = bthalloc_pkg::ST_FINISH;
          end else if (sum_c < CW'(WORDS) && sum_c <= tgt_c) begin
            pos_next = pos_sum;
          end else begin
            state_next = bthalloc_pkg::ST_FINISH;
          end
        end
      end

      bthalloc_pkg::ST_NEXT_CHK: begin
        // Successor header is on the read port; absorb it when it is free.
        if (!rd_used && rd_size >= SW'(bthalloc_pkg::MIN_BLOCK_W)) begin
          z1_next = z1 + rd_size;
        end
        if (s1 != '0) begin
          mem_raddr  = prev_addr[AW-1:0];
          state_next = bthalloc_pkg::ST_PREV_TAG;
        end else begin
          state_next = bthalloc_pkg::ST_WR_HDR1;
        end
      end

      bthalloc_pkg::ST_PREV_TAG: begin
        psz_next = rd_size;
        if (rd_size >= SW'(bthalloc_pkg::MIN_BLOCK_W) && PW'(rd_size) <= PW'(s1)) begin
          mem_raddr  = AW'(PW'(s1) - PW'(rd_size));
          state_next = bthalloc_pkg::ST_PREV_HDR;
        end else begin
          state_next = bthalloc_pkg::ST_WR_HDR1;
        end
      end

      bthalloc_pkg::ST_PREV_HDR: begin
        if (!rd_used) begin
          s1_next = AW'(PW'(s1) - PW'(psz));
          z1_next = z1 + psz;
        end
        state_next = bthalloc_pkg::ST_WR_HDR1;
      end

      bthalloc_pkg::ST_WR_HDR1: begin
        mem_we     = 1'b1;
        mem_waddr  = s1;
        mem_wdata  = {z1, u1};
        state_next = bthalloc_pkg::ST_WR_TRL1;
      end

      bthalloc_pkg::ST_WR_TRL1: begin
        mem_we     = 1'b1;
        mem_waddr  = trl1[AW-1:0];
        mem_wdata  = {z1, u1};
        state_next = two ? bthalloc_pkg::ST_WR_HDR2 : bthalloc_pkg::ST_FINISH;
      end

      bthalloc_pkg::ST_WR_HDR2: begin
        mem_we     = 1'b1;
        mem_waddr  = s2;
        mem_wdata  = {z2, 1'b0};
        state_next = bthalloc_pkg::ST_WR_TRL2;
      end

      bthalloc_pkg::ST_WR_TRL2: begin
        mem_we     = 1'b1;
        mem_waddr  = trl2[AW-1:0];
        mem_wdata  = {z2, 1'b0};
        state_next = bthalloc_pkg::ST_FINISH;
      end

      bthalloc_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = bthalloc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bthalloc_pkg::ST_IDLE;
      end
    endcase
  end

  // Every tag written describes a block of at least two words.
  a_tag_size: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> mem_wdata[TW-1:1] >= SW'(bthalloc_pkg::MIN_BLOCK_W))
    else $error("tag written with a block size below the minimum");

  // A trailer never lands before its own header.
  a_trailer_order: assert property (@(posedge clk) disable iff (rst)
    state == bthalloc_pkg::ST_WR_TRL1 |-> trl1 >= PW'(s1))
    else $error("trailer address below header address");

  // An accepted transaction always starts a walk or finishes at once.
  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=>
      (state == bthalloc_pkg::ST_WALK || state == bthalloc_pkg::ST_FINISH))
    else $error("accepted transaction took an unexpected path");

  // A result appears only after the sequencer has finished its work.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bthalloc_pkg::ST_FINISH)
    else $error("result raised outside the finish step");

endmodule

@@ hdl/boundary_tag_heap_allocator_top.sv @@
// Top level of the boundary-tag heap allocator: tag memory plus sequencer.
//
//   channel | signals                       | payload
//   --------+-------------------------------+----------------------------------
//   request | in_valid, in_ready, in_data   | func, request_bytes, payload_offset
//   result  | out_valid, out_ready, out_data| result_offset, status
//
// One transaction is in flight at a time. Allocate: the request is accepted, the walk
// reads the header of each block it visits from the tag memory, then 2 or 4 tag
// writes follow on a fit (none on a no-fit) and the result is loaded. Free: the same
// walk up to the target block, up to 3 neighbor reads for merging, 2 tag writes and
// the result load; a free that matches no live block skips the reads and writes.
// After reset the block writes the header and trailer tags of the single free block.
// A stalled result holds the sequencer in its finish step; no new request is taken.
module boundary_tag_heap_allocator_top #(
  parameter int HEAP_BYTES = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bthalloc_pkg::req_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bthalloc_pkg::rsp_t out_data
);

  localparam int WORDS = HEAP_BYTES / 8;
  localparam int AW    = $clog2(WORDS);
  localparam int TW    = $clog2(WORDS + 1) + 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [TW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [TW-1:0] mem_rdata;

  bthalloc_ram #(
    .WIDTH (TW),
    .DEPTH (WORDS)
  ) u_tags (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bthalloc_ctrl #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule
